>>> rtl/cau_pkg.sv
package cau_pkg;

    // Width of the operation code on the request channel.
    localparam int KIND_BITS = 3;

    // Operation codes as they arrive on the kind field.
    localparam logic [KIND_BITS-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_CMP = 3'd4;

    // Decoded operation carried down the pipeline.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CMP,
        OP_NONE
    } op_t;

    // Control and status that travel with every request.
    typedef struct packed {
        op_t  op;
        logic eq;
        logic dz;
        logic sat;
        logic ovf_re;
        logic ovf_im;
        logic neg_re;
        logic neg_im;
    } ctrl_t;

endpackage

>>> rtl/cau_prep.sv
module cau_prep #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cau_pkg::KIND_BITS-1:0]   kind,
    input  logic signed [WORD_BITS-1:0]     a_re,
    input  logic signed [WORD_BITS-1:0]     a_im,
    input  logic signed [WORD_BITS-1:0]     b_re,
    input  logic signed [WORD_BITS-1:0]     b_im,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cau_pkg::ctrl_t                  out_ctrl,
    output logic [3*WORD_BITS:0]            out_rem_re,
    output logic [3*WORD_BITS:0]            out_rem_im,
    output logic [2*WORD_BITS-1:0]          out_m,
    output logic [WORD_BITS:0]              out_q_re,
    output logic [WORD_BITS:0]              out_q_im
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int DW = 3 * W + 1;
    localparam int QW = W + 1;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // Saturate a sum one bit wider than the word.
    function automatic logic [W-1:0] clamp_add(input logic [W:0] s);
        logic [W-1:0] r;
        begin
            if (s[W] != s[W-1])
                r = s[W] ? MINV : MAXV;
            else
                r = s[W-1:0];
            return r;
        end
    endfunction

    // True when a wide signed value does not fit in the word.
    function automatic logic wide_ovf(input logic [SW-1:0] v);
        logic [SW-W:0] top;
        begin
            top = v[SW-1:W-1];
            return !((top == '0) || (top == '1));
        end
    endfunction

    // Saturate a wide signed value to the word.
    function automatic logic [W-1:0] clamp_wide(input logic [SW-1:0] v);
        logic [W-1:0] r;
        begin
            if (wide_ovf(v))
                r = v[SW-1] ? MINV : MAXV;
            else
                r = v[W-1:0];
            return r;
        end
    endfunction

    logic va_reg, vb_reg, vc_reg;
    logic rdy_a, rdy_b, rdy_c;

    cau_pkg::ctrl_t ctrl_a_next, ctrl_a_reg, ctrl_b_reg, ctrl_c_next, ctrl_c_reg;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    logic [W-1:0] res_re_a_next, res_im_a_next;
    logic [W-1:0] res_re_a_reg, res_im_a_reg, res_re_b_reg, res_im_b_reg;
    logic signed [W:0] sum_re, sum_im;

    logic signed [SW-1:0] sre_next, sim_next, sre_b_reg, sim_b_reg;
    logic [PW-1:0] m_next, m_b_reg;

    logic signed [SW-1:0] shf_re, shf_im;
    logic [SW-1:0] mag_re, mag_im;
    logic [DW-1:0] n_re, n_im, m_lim;
    logic [DW-1:0] rem_re_next, rem_im_next, rem_re_reg, rem_im_reg;
    logic [QW-1:0] q_re_next, q_im_next, q_re_reg, q_im_reg;
    logic [W-1:0] w_re, w_im;
    logic [PW-1:0] m_c_reg;

    // Ready ripples back through the three stages.
    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
            if (rdy_c)
                vc_reg <= vb_reg;
        end
    end

    // Stage A: decode, add or subtract, compare and all six products.
    always_comb
    begin
        ctrl_a_next = '0;
        sum_re      = '0;
        sum_im      = '0;
        unique case (kind)
            cau_pkg::KIND_ADD: ctrl_a_next.op = cau_pkg::OP_ADD;
            cau_pkg::KIND_SUB: ctrl_a_next.op = cau_pkg::OP_SUB;
            cau_pkg::KIND_MUL: ctrl_a_next.op = cau_pkg::OP_MUL;
            cau_pkg::KIND_DIV: ctrl_a_next.op = cau_pkg::OP_DIV;
            cau_pkg::KIND_CMP: ctrl_a_next.op = cau_pkg::OP_CMP;
            default:           ctrl_a_next.op = cau_pkg::OP_NONE;
        endcase
        if (ctrl_a_next.op == cau_pkg::OP_ADD)
        begin
            sum_re = (W+1)'(a_re) + (W+1)'(b_re);
            sum_im = (W+1)'(a_im) + (W+1)'(b_im);
        end
        else if (ctrl_a_next.op == cau_pkg::OP_SUB)
        begin
            sum_re = (W+1)'(a_re) - (W+1)'(b_re);
            sum_im = (W+1)'(a_im) - (W+1)'(b_im);
        end
        res_re_a_next   = clamp_add(sum_re);
        res_im_a_next   = clamp_add(sum_im);
        ctrl_a_next.sat = (sum_re[W] != sum_re[W-1]) || (sum_im[W] != sum_im[W-1]);
        ctrl_a_next.eq  = (ctrl_a_next.op == cau_pkg::OP_CMP) && (a_re == b_re) && (a_im == b_im);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            ctrl_a_reg   <= ctrl_a_next;
            res_re_a_reg <= res_re_a_next;
            res_im_a_reg <= res_im_a_next;
            p_rr_reg     <= a_re * b_re;
            p_ii_reg     <= a_im * b_im;
            p_ri_reg     <= a_re * b_im;
            p_ir_reg     <= a_im * b_re;
            sq_r_reg     <= b_re * b_re;
            sq_i_reg     <= b_im * b_im;
        end
    end

    // Stage B: combine the products into the multiply parts or the divide numerators, and the divisor.
    always_comb
    begin
        if (ctrl_a_reg.op == cau_pkg::OP_MUL)
        begin
            sre_next = SW'(p_rr_reg) - SW'(p_ii_reg);
            sim_next = SW'(p_ri_reg) + SW'(p_ir_reg);
        end
        else
        begin
            sre_next = SW'(p_rr_reg) + SW'(p_ii_reg);
            sim_next = SW'(p_ir_reg) - SW'(p_ri_reg);
        end
        m_next = $unsigned(sq_r_reg) + $unsigned(sq_i_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b)
        begin
            ctrl_b_reg   <= ctrl_a_reg;
            res_re_b_reg <= res_re_a_reg;
            res_im_b_reg <= res_im_a_reg;
            sre_b_reg    <= sre_next;
            sim_b_reg    <= sim_next;
            m_b_reg      <= m_next;
        end
    end

    // Stage C: pass add and subtract results on, finish the multiply and set up the divider remainders.
    always_comb
    begin
        shf_re = sre_b_reg >>> FRAC_BITS;
        shf_im = sim_b_reg >>> FRAC_BITS;
        mag_re = sre_b_reg[SW-1] ? SW'(-sre_b_reg) : SW'(sre_b_reg);
        mag_im = sim_b_reg[SW-1] ? SW'(-sim_b_reg) : SW'(sim_b_reg);
        n_re   = DW'(mag_re[PW-1:0]) << FRAC_BITS;
        n_im   = DW'(mag_im[PW-1:0]) << FRAC_BITS;
        m_lim  = DW'(m_b_reg) << (W + 1);

        ctrl_c_next = ctrl_b_reg;
        rem_re_next = '0;
        rem_im_next = '0;
        w_re        = '0;
        w_im        = '0;
        case (ctrl_b_reg.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                w_re = res_re_b_reg;
                w_im = res_im_b_reg;
            end
            cau_pkg::OP_MUL:
            begin
                w_re            = clamp_wide(shf_re);
                w_im            = clamp_wide(shf_im);
                ctrl_c_next.sat = wide_ovf(shf_re) || wide_ovf(shf_im);
            end
            cau_pkg::OP_DIV:
            begin
                rem_re_next        = n_re;
                rem_im_next        = n_im;
                ctrl_c_next.dz     = (m_b_reg == '0);
                ctrl_c_next.ovf_re = (n_re >= m_lim);
                ctrl_c_next.ovf_im = (n_im >= m_lim);
                ctrl_c_next.neg_re = sre_b_reg[SW-1];
                ctrl_c_next.neg_im = sim_b_reg[SW-1];
            end
            default:
            begin
                w_re = '0;
                w_im = '0;
            end
        endcase
        q_re_next = {w_re[W-1], w_re};
        q_im_next = {w_im[W-1], w_im};
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c)
        begin
            ctrl_c_reg <= ctrl_c_next;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            m_c_reg    <= m_b_reg;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
        end
    end

    assign out_valid  = vc_reg;
    assign out_ctrl   = ctrl_c_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_m      = m_c_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;

endmodule

>>> rtl/cau_div_cell.sv
module cau_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int BIT       = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cau_pkg::ctrl_t         in_ctrl,
    input  logic [3*WORD_BITS:0]   in_rem_re,
    input  logic [3*WORD_BITS:0]   in_rem_im,
    input  logic [2*WORD_BITS-1:0] in_m,
    input  logic [WORD_BITS:0]     in_q_re,
    input  logic [WORD_BITS:0]     in_q_im,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cau_pkg::ctrl_t         out_ctrl,
    output logic [3*WORD_BITS:0]   out_rem_re,
    output logic [3*WORD_BITS:0]   out_rem_im,
    output logic [2*WORD_BITS-1:0] out_m,
    output logic [WORD_BITS:0]     out_q_re,
    output logic [WORD_BITS:0]     out_q_im
);

    localparam int DW = 3 * WORD_BITS + 1;
    localparam int QW = WORD_BITS + 1;

    logic           valid_reg;
    cau_pkg::ctrl_t ctrl_reg;
    logic [DW-1:0]  md;
    logic           ge_re, ge_im, take;
    logic [DW-1:0]  rem_re_next, rem_im_next, rem_re_reg, rem_im_reg;
    logic [QW-1:0]  q_re_next, q_im_next, q_re_reg, q_im_reg;
    logic [2*WORD_BITS-1:0] m_reg;

    assign in_ready = !valid_reg || out_ready;

    // One restoring step: try to take the divisor at this quotient weight.
    always_comb
    begin
        md          = DW'(in_m) << BIT;
        take        = (in_ctrl.op == cau_pkg::OP_DIV);
        ge_re       = (in_rem_re >= md);
        ge_im       = (in_rem_im >= md);
        rem_re_next = (take && ge_re) ? (in_rem_re - md) : in_rem_re;
        rem_im_next = (take && ge_im) ? (in_rem_im - md) : in_rem_im;
        q_re_next   = in_q_re;
        q_im_next   = in_q_im;
        if (take)
        begin
            q_re_next[BIT] = ge_re;
            q_im_next[BIT] = ge_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            ctrl_reg   <= in_ctrl;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            m_reg      <= in_m;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_m      = m_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;

endmodule

>>> rtl/cau_finish.sv
module cau_finish #(
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cau_pkg::ctrl_t              in_ctrl,
    input  logic [WORD_BITS:0]          in_q_re,
    input  logic [WORD_BITS:0]          in_q_im,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] res_re,
    output logic signed [WORD_BITS-1:0] res_im,
    output logic                        is_equal,
    output logic                        div_by_zero,
    output logic                        saturated
);

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // True when a signed quotient magnitude leaves the word.
    function automatic logic q_ovf(input logic neg, input logic ovf, input logic [W:0] q);
        begin
            if (neg)
                return ovf || q[W] || (q[W-1] && (q[W-2:0] != '0));
            return ovf || q[W] || q[W-1];
        end
    endfunction

    // Apply the sign to a quotient magnitude and saturate.
    function automatic logic [W-1:0] q_word(input logic neg, input logic ovf,
                                            input logic [W:0] q);
        logic [W-1:0] r;
        begin
            if (q_ovf(neg, ovf, q))
                r = neg ? MINV : MAXV;
            else if (neg)
                r = -q[W-1:0];
            else
                r = q[W-1:0];
            return r;
        end
    endfunction

    logic         valid_reg;
    logic [W-1:0] re_next, im_next, re_reg, im_reg;
    logic         eq_next, dz_next, sat_next, eq_reg, dz_reg, sat_reg;

    assign in_ready = !valid_reg || out_ready;

    // Select the final words and flags for each operation.
    always_comb
    begin
        re_next  = in_q_re[W-1:0];
        im_next  = in_q_im[W-1:0];
        eq_next  = 1'b0;
        dz_next  = 1'b0;
        sat_next = in_ctrl.sat;
        case (in_ctrl.op)
            cau_pkg::OP_DIV:
            begin
                if (in_ctrl.dz)
                begin
                    re_next  = '0;
                    im_next  = '0;
                    dz_next  = 1'b1;
                    sat_next = 1'b0;
                end
                else
                begin
                    re_next  = q_word(in_ctrl.neg_re, in_ctrl.ovf_re, in_q_re);
                    im_next  = q_word(in_ctrl.neg_im, in_ctrl.ovf_im, in_q_im);
                    sat_next = q_ovf(in_ctrl.neg_re, in_ctrl.ovf_re, in_q_re)
                             || q_ovf(in_ctrl.neg_im, in_ctrl.ovf_im, in_q_im);
                end
            end
            cau_pkg::OP_CMP:
            begin
                re_next  = '0;
                im_next  = '0;
                eq_next  = in_ctrl.eq;
                sat_next = 1'b0;
            end
            cau_pkg::OP_NONE:
            begin
                re_next  = '0;
                im_next  = '0;
                sat_next = 1'b0;
            end
            default:
            begin
                sat_next = in_ctrl.sat;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            eq_reg  <= eq_next;
            dz_reg  <= dz_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid   = valid_reg;
    assign res_re      = re_reg;
    assign res_im      = im_reg;
    assign is_equal    = eq_reg;
    assign div_by_zero = dz_reg;
    assign saturated   = sat_reg;

endmodule

>>> rtl/complex_arith_unit.sv
// From request to result a request passes three front stages, one divider cell
// per quotient bit and one output register.
// Throughput: one request per cycle unless out_ready stalls the result; the divider is a row of WORD_BITS + 1
// restoring cells, each retiring one quotient bit for both parts.
// Reset clears only the valid bits of every stage; data registers are not reset.
module complex_arith_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cau_pkg::KIND_BITS-1:0] kind,
    input  logic signed [WORD_BITS-1:0]   a_re,
    input  logic signed [WORD_BITS-1:0]   a_im,
    input  logic signed [WORD_BITS-1:0]   b_re,
    input  logic signed [WORD_BITS-1:0]   b_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [WORD_BITS-1:0]   res_re,
    output logic signed [WORD_BITS-1:0]   res_im,
    output logic                          is_equal,
    output logic                          div_by_zero,
    output logic                          saturated
);

    localparam int W  = WORD_BITS;
    localparam int NC = W + 1;
    localparam int DW = 3 * W + 1;
    localparam int PW = 2 * W;

    // Chain links: index i feeds cell i, index NC feeds the output stage.
    logic           vld [NC+1];
    logic           rdy [NC+1];
    cau_pkg::ctrl_t ctl [NC+1];
    logic [W:0]     qre [NC+1];
    logic [W:0]     qim [NC+1];
    logic [DW-1:0]  rre [NC];
    logic [DW-1:0]  rim [NC];
    logic [PW-1:0]  mm  [NC];

    // Front end: decode, products, numerators and divider setup.
    cau_prep #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .a_re       (a_re),
        .a_im       (a_im),
        .b_re       (b_re),
        .b_im       (b_im),
        .out_valid  (vld[0]),
        .out_ready  (rdy[0]),
        .out_ctrl   (ctl[0]),
        .out_rem_re (rre[0]),
        .out_rem_im (rim[0]),
        .out_m      (mm[0]),
        .out_q_re   (qre[0]),
        .out_q_im   (qim[0])
    );

    // Divider row, most significant quotient bit first.
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        if (i < NC - 1)
        begin : g_mid
            cau_div_cell #(
                .WORD_BITS (WORD_BITS),
                .BIT       (W - i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (vld[i]),
                .in_ready   (rdy[i]),
                .in_ctrl    (ctl[i]),
                .in_rem_re  (rre[i]),
                .in_rem_im  (rim[i]),
                .in_m       (mm[i]),
                .in_q_re    (qre[i]),
                .in_q_im    (qim[i]),
                .out_valid  (vld[i+1]),
                .out_ready  (rdy[i+1]),
                .out_ctrl   (ctl[i+1]),
                .out_rem_re (rre[i+1]),
                .out_rem_im (rim[i+1]),
                .out_m      (mm[i+1]),
                .out_q_re   (qre[i+1]),
                .out_q_im   (qim[i+1])
            );
        end
        else
        begin : g_last
            cau_div_cell #(
                .WORD_BITS (WORD_BITS),
                .BIT       (W - i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (vld[i]),
                .in_ready   (rdy[i]),
                .in_ctrl    (ctl[i]),
                .in_rem_re  (rre[i]),
                .in_rem_im  (rim[i]),
                .in_m       (mm[i]),
                .in_q_re    (qre[i]),
                .in_q_im    (qim[i]),
                .out_valid  (vld[i+1]),
                .out_ready  (rdy[i+1]),
                .out_ctrl   (ctl[i+1]),
                .out_rem_re (),
                .out_rem_im (),
                .out_m      (),
                .out_q_re   (qre[i+1]),
                .out_q_im   (qim[i+1])
            );
        end
    end

    // Output register: sign, saturation and flags.
    cau_finish #(
        .WORD_BITS (WORD_BITS)
    ) u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (vld[NC]),
        .in_ready    (rdy[NC]),
        .in_ctrl     (ctl[NC]),
        .in_q_re     (qre[NC]),
        .in_q_im     (qim[NC]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res_re      (res_re),
        .res_im      (res_im),
        .is_equal    (is_equal),
        .div_by_zero (div_by_zero),
        .saturated   (saturated)
    );

endmodule

>>> rtl/cau_checker.sv
module cau_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [WORD_BITS-1:0] res_re,
    input logic signed [WORD_BITS-1:0] res_im,
    input logic                        is_equal,
    input logic                        div_by_zero,
    input logic                        saturated
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(res_re) && $stable(res_im)
            && $stable(is_equal) && $stable(div_by_zero) && $stable(saturated))
        else $error("result payload changed while stalled");

    // An equal compare result carries zero parts and no other flag.
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_equal |-> res_re == '0 && res_im == '0
            && !saturated && !div_by_zero)
        else $error("equal flag with nonzero parts or other flags");

    // A zero divisor returns zero without saturation.
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> res_re == '0 && res_im == '0 && !saturated)
        else $error("zero divisor result is not clean");

endmodule

bind complex_arith_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);
